>>> src/gmm_pkg.sv
// ----------------------------------------------------------------------------
// gmm_pkg
// Shared types, constants and the GF(2^13) multiplier for the modular
// polynomial multiplier.
// ----------------------------------------------------------------------------
package gmm_pkg;

   localparam int FIELD_BITS    = 13;
   localparam int DEGREE_T_DEF  = 128;

   typedef logic [FIELD_BITS-1:0] felem_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_CLEAR,
      OP_LOAD,
      OP_SQUARE,
      OP_MAC,
      OP_ALIGN,
      OP_REDUCE,
      OP_DRAIN
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      felem_type   x;
      felem_type   a_data;
      felem_type   b_data;
      felem_type   g_data;
   } cell_ctrl_type;

   typedef struct packed {
      logic       valid;
      logic       final_grp;
      logic [3:0] keep;
   } rsp_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MAC,
      ST_ALIGN,
      ST_REDUCE,
      ST_DRAIN
   } state_type;

   // z^13 = z^7 + z^6 + z^5 + 1, folded twice
   function automatic felem_type gf_mul(input felem_type x, input felem_type y);
      logic [24:0] p;
      logic [11:0] h1;
      logic [18:0] f1;
      logic [5:0]  h2;
      felem_type   res;
      p = '0;
      for (int k = 0; k < FIELD_BITS; k++) begin
         if (y[k]) begin
            p = p ^ ({12'd0, x} << k);
         end
      end
      h1  = p[24:13];
      f1  = {6'd0, p[12:0]} ^ {7'd0, h1} ^ {2'd0, h1, 5'd0} ^ {1'd0, h1, 6'd0} ^ {h1, 7'd0};
      h2  = f1[18:13];
      res = f1[12:0] ^ {7'd0, h2} ^ {2'd0, h2, 5'd0} ^ {1'd0, h2, 6'd0} ^ {h2, 7'd0};
      return res;
   endfunction

endpackage

>>> src/gmm_cell.sv
// ----------------------------------------------------------------------------
// gmm_cell
// One cell of the coefficient chain: holds one coefficient of a, b, g and
// the product, with one field multiplier.
// ----------------------------------------------------------------------------
module gmm_cell import gmm_pkg::*; #(
   parameter int INDEX    = 0,
   parameter int DEGREE_T = DEGREE_T_DEF,
   parameter int LI_W     = $clog2(DEGREE_T + 2)
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl_i,
   input  logic [LI_W-1:0] load_sel_i,
   input  felem_type     prev_r_i,
   input  felem_type     prev_g_i,
   input  felem_type     prev_a_i,
   input  felem_type     up_r_i,
   output felem_type     r_o,
   output felem_type     g_o,
   output felem_type     a_o
);

   localparam bit LOADABLE = (INDEX <= DEGREE_T);

   felem_type r_ff, r_in;
   felem_type g_ff, g_in;
   felem_type a_ff, a_in;
   felem_type b_ff, b_in;
   felem_type mul_y;
   felem_type mul_p;
   logic      sel;

   assign sel   = LOADABLE && (load_sel_i == LI_W'(INDEX));
   assign mul_y = (ctrl_i.op == OP_MAC) ? b_ff : g_ff;
   assign mul_p = gf_mul(ctrl_i.x, mul_y);

   always_comb begin
      r_in = r_ff;
      g_in = g_ff;
      a_in = a_ff;
      b_in = b_ff;
      unique case (ctrl_i.op)
         OP_CLEAR: begin
            r_in = '0;
            g_in = '0;
            a_in = '0;
            b_in = '0;
         end
         OP_LOAD: begin
            if (sel) begin
               a_in = ctrl_i.a_data;
               b_in = ctrl_i.b_data;
               g_in = ctrl_i.g_data;
            end
         end
         OP_SQUARE: b_in = a_ff;
         OP_MAC: begin
            r_in = prev_r_i ^ mul_p;
            a_in = prev_a_i;
         end
         OP_ALIGN:  g_in = prev_g_i;
         OP_REDUCE: r_in = prev_r_i ^ mul_p;
         OP_DRAIN:  r_in = up_r_i;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff <= '0;
         g_ff <= '0;
         a_ff <= '0;
         b_ff <= '0;
      end else begin
         r_ff <= r_in;
         g_ff <= g_in;
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   assign r_o = r_ff;
   assign g_o = g_ff;
   assign a_o = a_ff;

endmodule

>>> src/gmm_ctrl.sv
// ----------------------------------------------------------------------------
// gmm_ctrl
// Sequencer for the cell chain: load, optional squaring, multiply, align modulus, reduce, drain.
// ----------------------------------------------------------------------------
module gmm_ctrl import gmm_pkg::*; #(
   parameter int DEGREE_T = DEGREE_T_DEF,
   parameter int LI_W     = $clog2(DEGREE_T + 2),
   parameter int CNT_W    = $clog2(2 * DEGREE_T + 2),
   parameter int NG       = (DEGREE_T + 4) / 4,
   parameter int GRP_W    = $clog2(NG + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            last_i,
   input  felem_type       a_data_i,
   input  felem_type       b_data_i,
   input  felem_type       g_data_i,
   input  logic            csr_we,
   input  logic            csr_wdata,
   input  felem_type       r_top_i,
   input  felem_type       g_top_i,
   input  felem_type       a_top_i,
   output logic            busy,
   output cell_ctrl_type   cell_ctrl_o,
   output logic [LI_W-1:0] load_sel_o,
   output rsp_ctrl_type    rsp_o
);

   localparam int P      = 2 * DEGREE_T;
   localparam int LAST_M = DEGREE_T - 4 * (NG - 1);

   state_type        state_ff, state_in;
   logic [LI_W-1:0]  load_idx_ff, load_idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] upd_ff, upd_in;
   logic [GRP_W-1:0] grp_ff, grp_in;
   logic             sq_ff, sq_in;
   logic             is_final;

   assign is_final = (grp_ff == GRP_W'(NG - 1));
   assign sq_in    = csr_we ? csr_wdata : sq_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start && last_i) state_in = ST_PREP;
         ST_PREP:   state_in = ST_MAC;
         ST_MAC:    if (cnt_ff == CNT_W'(DEGREE_T)) state_in = ST_ALIGN;
         ST_ALIGN: begin
            if (g_top_i != '0) state_in = ST_REDUCE;
            else if (cnt_ff == CNT_W'(P)) state_in = ST_DRAIN;  // zero modulus
         end
         ST_REDUCE: if (cnt_ff == CNT_W'(P)) state_in = ST_DRAIN;
         ST_DRAIN:  if (is_final) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy               = (state_ff != ST_IDLE);
      cell_ctrl_o.op     = OP_HOLD;
      cell_ctrl_o.x      = '0;
      cell_ctrl_o.a_data = a_data_i;
      cell_ctrl_o.b_data = b_data_i;
      cell_ctrl_o.g_data = g_data_i;
      load_sel_o         = load_idx_ff;
      rsp_o              = '0;
      load_idx_in        = load_idx_ff;
      cnt_in             = cnt_ff;
      upd_in             = upd_ff;
      grp_in             = grp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && (load_idx_ff <= LI_W'(DEGREE_T))) begin
               cell_ctrl_o.op = OP_LOAD;
               load_idx_in    = load_idx_ff + 1'b1;
            end
            cnt_in = '0;
         end
         ST_PREP: cell_ctrl_o.op = sq_ff ? OP_SQUARE : OP_HOLD;
         ST_MAC: begin
            cell_ctrl_o.op = OP_MAC;
            cell_ctrl_o.x  = a_top_i;
            cnt_in = (cnt_ff == CNT_W'(DEGREE_T)) ? '0 : cnt_ff + 1'b1;
         end
         ST_ALIGN: begin
            // rotate g until its leading coefficient lands in cell 0
            cell_ctrl_o.op = OP_ALIGN;
            cnt_in = cnt_ff + 1'b1;
            if (g_top_i != '0) begin
               upd_in = cnt_ff + 1'b1;
               cnt_in = '0;
            end
         end
         ST_REDUCE: begin
            // full turn of the ring; only the first upd_ff steps subtract
            cell_ctrl_o.op = OP_REDUCE;
            cell_ctrl_o.x  = (cnt_ff < upd_ff) ? r_top_i : '0;
            cnt_in = (cnt_ff == CNT_W'(P)) ? '0 : cnt_ff + 1'b1;
         end
         ST_DRAIN: begin
            rsp_o.valid     = 1'b1;
            rsp_o.final_grp = is_final;
            for (int m = 0; m < 4; m++) begin
               rsp_o.keep[m] = !(is_final && (m > LAST_M));
            end
            cell_ctrl_o.op = is_final ? OP_CLEAR : OP_DRAIN;
            grp_in         = is_final ? '0 : grp_ff + 1'b1;
            if (is_final) load_idx_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         load_idx_ff <= '0;
         cnt_ff      <= '0;
         upd_ff      <= '0;
         grp_ff      <= '0;
         sq_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         load_idx_ff <= load_idx_in;
         cnt_ff      <= cnt_in;
         upd_ff      <= upd_in;
         grp_ff      <= grp_in;
         sq_ff       <= sq_in;
      end
   end

   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_o.valid && rsp_o.final_grp) |=> (state_ff == ST_IDLE))
      else $error("final group not followed by idle");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && last_i) |=> busy)
      else $error("last request did not start computation");

   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      load_idx_ff <= LI_W'(DEGREE_T + 1))
      else $error("load index overran");

   a_idle_group: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (grp_ff == '0))
      else $error("group counter not cleared");

endmodule

>>> src/gf2m_poly_modmul_top.sv
// ----------------------------------------------------------------------------
// gf2m_poly_modmul_top
// Product of two polynomials over GF(2^13) modulo g, on a ring of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests carry coefficient i of a, b and g on req_a_coef, req_b_coef and
//   req_g_coef, i ascending from 0; a request is taken when start is high and
//   busy is low, one per cycle while loading. Requests past index DEGREE_T
//   are dropped. req_last starts the run; coefficients not loaded are zero.
//   csr_we/csr_wdata set square mode (a*a mod g), sampled when the run starts.
//   After the last request busy stays high through the prep, multiply,
//   align, reduce and drain phases (for a zero g the reduce phase is
//   skipped), with NG = ceil((DEGREE_T+1)/4) result groups. In the drain
//   each cycle strobes rsp_valid for one result group of four coefficients;
//   rsp_final_group marks the last. The rate is set by the ring of
//   2*DEGREE_T+1 cells, which moves one position per cycle in the multiply,
//   align and reduce phases and by four in the drain. The receiver cannot
//   stall results. Synchronous reset clears the ring, the load index and
//   square mode.
// ----------------------------------------------------------------------------
module gf2m_poly_modmul_top import gmm_pkg::*; #(
   parameter int DEGREE_T = DEGREE_T_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   output logic      busy,
   input  felem_type req_a_coef,
   input  felem_type req_b_coef,
   input  felem_type req_g_coef,
   input  logic      req_last,
   input  logic      csr_we,
   input  logic      csr_wdata,
   output logic      rsp_valid,
   output felem_type rsp_coef_0,
   output felem_type rsp_coef_1,
   output felem_type rsp_coef_2,
   output felem_type rsp_coef_3,
   output logic      rsp_final_group
);

   localparam int P     = 2 * DEGREE_T;
   localparam int LI_W  = $clog2(DEGREE_T + 2);
   localparam int CNT_W = $clog2(2 * DEGREE_T + 2);
   localparam int NG    = (DEGREE_T + 4) / 4;
   localparam int GRP_W = $clog2(NG + 1);

   cell_ctrl_type   cell_ctrl;
   rsp_ctrl_type    rsp;
   logic [LI_W-1:0] load_sel;
   felem_type       r_q [P+1];
   felem_type       g_q [P+1];
   felem_type       a_q [P+1];

   gmm_ctrl #(
      .DEGREE_T (DEGREE_T),
      .LI_W     (LI_W),
      .CNT_W    (CNT_W),
      .NG       (NG),
      .GRP_W    (GRP_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .last_i      (req_last),
      .a_data_i    (req_a_coef),
      .b_data_i    (req_b_coef),
      .g_data_i    (req_g_coef),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .r_top_i     (r_q[P]),
      .g_top_i     (g_q[P]),
      .a_top_i     (a_q[DEGREE_T]),
      .busy        (busy),
      .cell_ctrl_o (cell_ctrl),
      .load_sel_o  (load_sel),
      .rsp_o       (rsp)
   );

   for (genvar k = 0; k <= P; k++) begin : g_ring
      localparam int PK = (k == 0) ? P : k - 1;
      localparam int UK = (k + 4 <= P) ? k + 4 : P;
      felem_type prev_a;
      felem_type up_r;

      assign prev_a = (k == 0) ? '0 : a_q[PK];
      assign up_r   = (k + 4 <= P) ? r_q[UK] : '0;

      gmm_cell #(
         .INDEX    (k),
         .DEGREE_T (DEGREE_T),
         .LI_W     (LI_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl_i     (cell_ctrl),
         .load_sel_i (load_sel),
         .prev_r_i   (r_q[PK]),
         .prev_g_i   (g_q[PK]),
         .prev_a_i   (prev_a),
         .up_r_i     (up_r),
         .r_o        (r_q[k]),
         .g_o        (g_q[k]),
         .a_o        (a_q[k])
      );
   end

   assign rsp_valid       = rsp.valid;
   assign rsp_final_group = rsp.final_grp;
   assign rsp_coef_0      = rsp.keep[0] ? r_q[0] : '0;
   assign rsp_coef_1      = rsp.keep[1] ? r_q[1] : '0;
   assign rsp_coef_2      = rsp.keep[2] ? r_q[2] : '0;
   assign rsp_coef_3      = rsp.keep[3] ? r_q[3] : '0;

endmodule

>>> tb/gf2m_poly_modmul_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gf2m_poly_modmul_top_test
// Loads coefficient runs of a, b and g with random gaps, predicts a*b (or
// a*a) mod g over GF(2^13) and checks every result group in order.
// ----------------------------------------------------------------------------
module gf2m_poly_modmul_top_test import gmm_pkg::*;;

   localparam int  DEG      = DEGREE_T_DEF;
   localparam int  NGROUPS  = (DEG + 1 + 3) / 4;
   localparam int  WD_LIMIT = 6000;
   localparam logic [13:0] FIELD_POLY = 14'h20E1;
   localparam felem_type   FMAX = '1;

   typedef struct {
      felem_type a, b, g;
      logic      last;
   } coef_req_type;

   typedef struct {
      felem_type  c[4];
      logic       final_grp;
   } group_type;

   logic      clock = 0;
   logic      reset = 1;
   logic      start = 0;
   logic      busy;
   felem_type req_a_coef = '0, req_b_coef = '0, req_g_coef = '0;
   logic      req_last = 0;
   logic      csr_we = 0, csr_wdata = 0;
   logic      rsp_valid;
   felem_type rsp_coef_0, rsp_coef_1, rsp_coef_2, rsp_coef_3;
   logic      rsp_final_group;

   gf2m_poly_modmul_top DUT (.*);

   always #6 clock = ~clock;

   coef_req_type pending[$];
   group_type    expected_groups[$];
   int        errors = 0;
   int        gap = 0;
   bit        idle_on = 1;
   int        quiet = 0;

   // predictor state
   felem_type a_mem[DEG+1], b_mem[DEG+1], g_mem[DEG+1];
   felem_type prod[2*DEG+1];
   int        load_idx = 0;
   logic      sq_mode = 0;

   function automatic felem_type fmul(felem_type x, felem_type y);
      logic [13:0] xs;
      felem_type   acc;
      xs  = {1'b0, x};
      acc = '0;
      for (int k = 0; k < 13; k++) begin
         if (y[k]) acc ^= xs[12:0];
         xs = xs << 1;
         if (xs[13]) xs ^= FIELD_POLY;
      end
      return acc;
   endfunction

   task automatic modmul_predict(input coef_req_type r);
      int     dg;
      felem_type c;
      group_type grp;
      if (load_idx <= DEG) begin
         a_mem[load_idx] = r.a;
         b_mem[load_idx] = r.b;
         g_mem[load_idx] = r.g;
         load_idx++;
      end
      if (!r.last) return;
      foreach (prod[i]) prod[i] = '0;
      for (int i = 0; i <= DEG; i++)
         if (a_mem[i] != 0)
            for (int j = 0; j <= DEG; j++)
               prod[i+j] ^= fmul(a_mem[i], sq_mode ? a_mem[j] : b_mem[j]);
      dg = -1;
      for (int i = DEG; i >= 0 && dg < 0; i--)
         if (g_mem[i] != 0) dg = i;
      if (dg >= 0)
         for (int i = 2*DEG; i >= dg; i--) begin
            c = prod[i];
            for (int j = 0; j <= dg; j++) prod[i-dg+j] ^= fmul(c, g_mem[j]);
         end
      for (int k = 0; k < NGROUPS; k++) begin
         for (int m = 0; m < 4; m++)
            grp.c[m] = (k*4 + m <= DEG) ? prod[k*4 + m] : '0;
         grp.final_grp = (k == NGROUPS - 1);
         expected_groups.push_back(grp);
      end
      foreach (a_mem[i]) begin
         a_mem[i] = '0; b_mem[i] = '0; g_mem[i] = '0;
      end
      load_idx = 0;
   endtask

   // driver
   always @(posedge clock) begin
      coef_req_type cur, nxt;
      if (reset) begin
         start <= 0;
         gap   <= 0;
      end else begin
         if (start && !busy) begin
            cur.a = req_a_coef; cur.b = req_b_coef;
            cur.g = req_g_coef; cur.last = req_last;
            modmul_predict(cur);
         end
         if (!start || !busy) begin
            if (gap > 0) begin
               gap   <= gap - 1;
               start <= 0;
            end else if (pending.size() > 0) begin
               nxt = pending.pop_front();
               req_a_coef <= nxt.a;
               req_b_coef <= nxt.b;
               req_g_coef <= nxt.g;
               req_last   <= nxt.last;
               start      <= 1;
               if (idle_on && $urandom_range(0, 5) == 0) gap <= $urandom_range(1, 17);
            end else begin
               start <= 0;
            end
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      group_type e;
      felem_type got[4];
      if (!reset) begin
         if (rsp_valid) begin
            got = '{rsp_coef_0, rsp_coef_1, rsp_coef_2, rsp_coef_3};
            if (expected_groups.size() == 0) begin
               $error("unexpected result group");
               errors++;
            end else begin
               e = expected_groups.pop_front();
               for (int m = 0; m < 4; m++)
                  if (got[m] !== e.c[m]) begin
                     $error("coef_%0d: expected %h, got %h", m, e.c[m], got[m]);
                     errors++;
                  end
               if (rsp_final_group !== e.final_grp) begin
                  $error("final_group: expected %b, got %b", e.final_grp, rsp_final_group);
                  errors++;
               end
            end
         end
         if (rsp_valid || (start && !busy)) quiet <= 0;
         else quiet <= quiet + 1;
         if (quiet >= WD_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   function automatic felem_type rcoef();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return FMAX;
         default: return felem_type'($urandom);
      endcase
   endfunction

   task automatic push_req(felem_type a, felem_type b, felem_type g, logic last);
      coef_req_type r;
      r.a = a; r.b = b; r.g = g; r.last = last;
      pending.push_back(r);
   endtask

   task automatic push_random_run(int len);
      felem_type g;
      for (int i = 0; i < len; i++) begin
         g = rcoef();
         // mostly keep the top of g nonzero so reduction actually runs
         if (i == len - 1 && g == 0 && $urandom_range(0, 3) != 0) g = 1;
         push_req(rcoef(), rcoef(), g, i == len - 1);
      end
   endtask

   task automatic drain_and_set_mode(logic mode);
      wait (pending.size() == 0 && !start);
      wait (expected_groups.size() == 0);
      repeat (20) @(posedge clock);
      csr_we    <= 1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we    <= 0;
      sq_mode = mode;
   endtask

   initial begin
      foreach (a_mem[i]) begin
         a_mem[i] = '0; b_mem[i] = '0; g_mem[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 0;
      drain_and_set_mode(0);

      // single item: all max, g of degree 0
      push_req(FMAX, FMAX, FMAX, 1);
      // zero modulus, short run
      push_req(FMAX, 13'h0001, '0, 0);
      push_req(13'h1555, 13'h0AAA, '0, 0);
      push_req(FMAX, FMAX, '0, 1);
      // non-monic modulus
      push_req(13'h0003, 13'h1000, 13'h0001, 0);
      push_req(FMAX, 13'h0002, 13'h0ABC, 0);
      push_req(13'h1234, FMAX, 13'h1FFE, 0);
      push_req(13'h0AAA, 13'h1555, 13'h0777, 1);
      // all zeros
      push_req('0, '0, '0, 1);

      drain_and_set_mode(1);
      push_req(FMAX, 13'h1111, 13'h0005, 0);
      push_req(13'h1000, '0, 13'h1FFF, 0);
      push_req(13'h0001, FMAX, 13'h0002, 1);

      for (int p = 0; p < 6; p++) begin
         drain_and_set_mode(p[0]);
         if (p == 5) idle_on = 0;
         if (p == 3) push_random_run(DEG + 3);   // overflow: excess items dropped
         for (int r = 0; r < 2; r++) push_random_run($urandom_range(1, 5));
      end

      wait (pending.size() == 0 && !start);
      wait (expected_groups.size() == 0);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
